// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the deserializer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clock, quiet while reset is high.
`define ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Plain invariant checked at every rising edge of clock, quiet while reset is high.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

`endif

// ===== sv/csd_pkg.sv =====
// Shared widths, result kinds and types of the compact size deserializer.
package csd_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 32;
   localparam int KIND_W = 2;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_LEN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

   // Prefix markers that announce 2, 4 and 8 extension bytes.
   localparam logic [BYTE_W-1:0] MARK_U16 = 8'd253;
   localparam logic [BYTE_W-1:0] MARK_U32 = 8'd254;
   localparam logic [BYTE_W-1:0] MARK_U64 = 8'd255;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] data;
      logic              last;
   } rsp_type;

endpackage

// ===== sv/csd_req_if.sv =====
// Input byte channel of the compact size deserializer.
interface csd_req_if;
   logic                       valid;
   logic                       ready;
   logic [csd_pkg::BYTE_W-1:0] in_byte;
   logic                       in_end;

   modport source (output valid, output in_byte, output in_end, input ready);
   modport sink (input valid, input in_byte, input in_end, output ready);
endinterface

// ===== sv/csd_rsp_if.sv =====
// Result channel of the compact size deserializer.
interface csd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [csd_pkg::KIND_W-1:0] out_kind;
   logic [csd_pkg::LEN_W-1:0]  out_length;
   logic [csd_pkg::BYTE_W-1:0] out_byte;
   logic                       out_last;

   modport source (output valid, output out_kind, output out_length, output out_byte,
                   output out_last, input ready);
   modport sink (input valid, input out_kind, input out_length, input out_byte,
                 input out_last, output ready);
endinterface

// ===== sv/compact_size_string_deserializer.sv =====
// Top level of the compact size length and string deserializer.
//
// The req_ch channel brings one raw byte per beat, with in_end set on the final
// byte of a buffer. The block decodes a little-endian compact size prefix (one
// byte below 253, or a marker followed by 2, 4 or 8 bytes, kept to 32 bits) and
// sends the length as one beat on rsp_ch. In string mode a nonzero length is
// followed by that many payload beats, the last one flagged. A buffer that ends
// inside a field gives one error beat; payload beats already sent are void.
// csr_we writes csr_wdata into the string mode bit; it is sampled only when a
// length completes.
// Every input byte is decoded in the cycle in which it is accepted, so a beat
// can be taken on every clock while req_ch.ready is high. A result is written
// into the result register, or into one skid register behind it when the
// receiver stalls with a result already waiting. The two registers part the
// two sides: req_ch.ready drops only once both hold a result.
// A synchronous reset empties both registers, returns the parser to the prefix
// phase and sets string mode.
module compact_size_string_deserializer (
   input logic       clock,
   input logic       reset,
   csd_req_if.sink   req_ch,
   csd_rsp_if.source rsp_ch,
   input logic       csr_we,
   input logic       csr_wdata
);

`include "assert_macros.svh"

   // Parser phases.
   localparam logic [1:0] PH_PREFIX  = 2'd0;
   localparam logic [1:0] PH_EXT     = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;

   logic                       mode_ff;
   logic [1:0]                 phase_ff, phase_in;
   logic [3:0]                 left_ff, left_in;
   logic [2:0]                 shift_ff, shift_in;
   logic [csd_pkg::LEN_W-1:0]  accum_ff, accum_in;
   logic [csd_pkg::LEN_W-1:0]  payload_ff, payload_in;

   logic                       out_valid_ff, out_valid_in;
   csd_pkg::rsp_type           out_ff, out_in;
   logic                       skid_valid_ff, skid_valid_in;
   csd_pkg::rsp_type           skid_ff, skid_in;

   logic                       accept;
   logic                       out_take;
   logic                       res_valid;
   csd_pkg::rsp_type           res;

   logic [csd_pkg::BYTE_W-1:0] b;
   logic                       b_end;
   logic [csd_pkg::LEN_W-1:0]  ext_accum;
   logic [3:0]                 ext_left;
   logic [csd_pkg::LEN_W-1:0]  payload_dec;
   logic [csd_pkg::LEN_W-1:0]  fin_len;
   logic                       fin_go;

   assign b        = req_ch.in_byte;
   assign b_end    = req_ch.in_end;
   assign accept   = req_ch.valid && req_ch.ready;
   assign out_take = out_valid_ff && rsp_ch.ready;

   // Only the first four extension bytes land in the 32-bit length.
   assign ext_accum = shift_ff[2] ? accum_ff :
                      (accum_ff | (csd_pkg::LEN_W'(b) << {shift_ff[1:0], 3'b000}));
   assign ext_left    = left_ff - 4'd1;
   assign payload_dec = payload_ff - 1'b1;

   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      shift_in   = shift_ff;
      accum_in   = accum_ff;
      payload_in = payload_ff;
      res_valid  = 1'b0;
      res        = '{kind: csd_pkg::KIND_LEN, length: '0, data: '0, last: 1'b0};
      fin_go     = 1'b0;
      fin_len    = ext_accum;

      unique case (phase_ff)
         PH_EXT: begin
            shift_in = shift_ff + 3'd1;
            left_in  = ext_left;
            accum_in = ext_accum;
            if (ext_left == 4'd0) begin
               fin_go  = 1'b1;
               fin_len = ext_accum;
            end else if (b_end) begin
               res_valid = 1'b1;
               res.kind  = csd_pkg::KIND_ERR;
            end
         end
         PH_PAYLOAD: begin
            payload_in = payload_dec;
            res_valid  = 1'b1;
            res.kind   = csd_pkg::KIND_BYTE;
            res.data   = b;
            if (payload_dec == '0) begin
               phase_in = PH_PREFIX;
               res.last = 1'b1;
            end else if (b_end) begin
               res.kind = csd_pkg::KIND_ERR;
               res.data = '0;
            end
         end
         default: begin
            if (b < csd_pkg::MARK_U16) begin
               fin_go  = 1'b1;
               fin_len = csd_pkg::LEN_W'(b);
            end else if (b_end) begin
               res_valid = 1'b1;
               res.kind  = csd_pkg::KIND_ERR;
            end else begin
               phase_in = PH_EXT;
               shift_in = 3'd0;
               accum_in = '0;
               left_in  = (b == csd_pkg::MARK_U16) ? 4'd2 :
                          ((b == csd_pkg::MARK_U32) ? 4'd4 : 4'd8);
            end
         end
      endcase

      // A complete length ends the field, opens a payload, or gives an error if the buffer ends first.
      if (fin_go) begin
         left_in    = 4'd0;
         shift_in   = 3'd0;
         accum_in   = '0;
         res_valid  = 1'b1;
         res.length = fin_len;
         if (mode_ff && (fin_len != '0)) begin
            if (b_end) begin
               res.kind   = csd_pkg::KIND_ERR;
               res.length = '0;
            end else begin
               phase_in   = PH_PAYLOAD;
               payload_in = fin_len;
            end
         end else begin
            phase_in   = PH_PREFIX;
            payload_in = '0;
            res.last   = 1'b1;
         end
      end

      // An error closes the field and clears the parser.
      if (res_valid && (res.kind == csd_pkg::KIND_ERR)) begin
         res.last   = 1'b1;
         phase_in   = PH_PREFIX;
         left_in    = 4'd0;
         shift_in   = 3'd0;
         accum_in   = '0;
         payload_in = '0;
      end
   end

   // Result register with a skid register behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = accept && res_valid;
            skid_in       = res;
         end else begin
            out_valid_in = accept && res_valid;
            out_in       = res;
         end
      end else if (accept && res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b1;
         phase_ff      <= PH_PREFIX;
         left_ff       <= 4'd0;
         shift_ff      <= 3'd0;
         accum_ff      <= '0;
         payload_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         if (accept) begin
            phase_ff   <= phase_in;
            left_ff    <= left_in;
            shift_ff   <= shift_in;
            accum_ff   <= accum_in;
            payload_ff <= payload_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_ch.ready      = !skid_valid_ff;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_kind   = out_ff.kind;
   assign rsp_ch.out_length = out_ff.length;
   assign rsp_ch.out_byte   = out_ff.data;
   assign rsp_ch.out_last   = out_ff.last;

   `ASSERT_IMPL(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid full with result register empty")
   `ASSERT_IMPL(a_skid_after_stall, skid_valid_ff, $past(out_valid_ff && !rsp_ch.ready) || $past(skid_valid_ff), "skid filled without a stall")
   `ASSERT_IMPL(a_payload_nonzero, phase_ff == PH_PAYLOAD, payload_ff != '0, "payload phase with no bytes left")
   `ASSERT_IMPL(a_ext_nonzero, phase_ff == PH_EXT, left_ff != 4'd0, "extension phase with no bytes left")

endmodule
